[hdl/distance_vector_route_table_assert.svh]
// Assertion macros for the distance-vector route table.
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define DVRT_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define DVRT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define DVRT_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define DVRT_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

[hdl/dvrt_pkg.sv]
// Shared types and constants for the distance-vector route table.
package dvrt_pkg;
    localparam logic [1:0] OP_UPDATE  = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_PERIOD  = 2'd2;
    localparam logic [1:0] OP_LOOKUP  = 2'd3;

    localparam logic [1:0] KIND_ADV     = 2'd0;
    localparam logic [1:0] KIND_FORWARD = 2'd1;
    localparam logic [1:0] KIND_DELIVER = 2'd2;
    localparam logic [1:0] KIND_DROP    = 2'd3;

    localparam logic [2:0] REG_SELF_ID   = 3'd0;
    localparam logic [2:0] REG_INFINITY  = 3'd1;
    localparam logic [2:0] REG_TIMEOUT   = 3'd2;
    localparam logic [2:0] REG_SPLIT     = 3'd3;
    localparam logic [2:0] REG_POISON    = 3'd4;
    localparam logic [2:0] REG_PORT_CNT  = 3'd5;

    localparam logic [7:0] DEFAULT_INFINITY = 8'd16;
    localparam int unsigned MAX_RESULTS = 64;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture input transaction
        logic update;     // apply update to table
        logic poison;     // write infinity to scanned entry
        logic forget;     // clear seen flag of scanned neighbour
        logic scan_start; // reset scan counters
        logic next_port;  // advance neighbour counter
        logic next_dest;  // advance destination counter
        logic adv_start;  // reset advert port counter, latch advert dest
        logic adv_step;   // advance advert port counter
        logic adv_sel_scan; // advert dest from scan counter, else input dest
    } dvrt_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic accept;      // update replaces entry
        logic upd_ok;      // update port active
        logic nb_expired;  // scanned neighbour timed out
        logic port_done;   // neighbour scan at end
        logic dest_done;   // destination scan at end
        logic dest_hit;    // scanned entry matches tick or period rule
        logic adv_emit;    // current advert port produces a result
        logic adv_done;    // advert port counter at end
    } dvrt_stat_t;
endpackage

[hdl/dvrt_datapath.sv]
// Route table storage, neighbour timers and result formation.
module dvrt_datapath #(
    parameter int NUM_NODES = 16,
    parameter int NUM_PORTS = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dvrt_pkg::dvrt_cmd_t  cmd,
    output dvrt_pkg::dvrt_stat_t stat,
    input  logic [1:0]           s_operation,
    input  logic [1:0]           s_in_port,
    input  logic [3:0]           s_dest_id,
    input  logic [7:0]           s_adv_cost,
    input  logic [31:0]          s_now,
    input  logic [3:0]           self_id,
    input  logic [7:0]           small_infinity,
    input  logic [31:0]          peer_timeout,
    input  logic                 split_horizon,
    input  logic                 poison_reverse,
    input  logic [2:0]           port_count,
    output logic [1:0]           res_kind,
    output logic [1:0]           res_port,
    output logic [3:0]           res_dest,
    output logic [7:0]           res_cost
);
    localparam int NW = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
    localparam int PW = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;

    logic [NUM_NODES-1:0] valid_reg;
    logic [1:0]           hop_reg [NUM_NODES];
    logic [7:0]           cost_reg [NUM_NODES];
    logic [NUM_PORTS-1:0] seen_reg;
    logic [31:0]          last_reg [NUM_PORTS];

    logic [1:0]  op_reg;
    logic [1:0]  port_reg;
    logic [3:0]  dest_reg;
    logic [7:0]  adv_reg;
    logic [31:0] now_reg;
    logic [NW:0] dcnt_reg;
    logic [PW:0] pcnt_reg;
    logic [2:0]  acnt_reg;
    logic [3:0]  adest_reg;

    logic [7:0] inf;
    logic [2:0] act_ports;
    logic [8:0] c_sum;
    logic [7:0] c_new;
    logic       dest_in;
    logic [NW-1:0] didx;
    logic [NW-1:0] sidx;
    logic [NW-1:0] aidx;
    logic [PW-1:0] pidx;
    logic [31:0] age;
    logic        a_self;
    logic        a_back;
    logic [7:0]  a_cost;

    always_comb begin
        inf = (small_infinity == 8'd0) ? dvrt_pkg::DEFAULT_INFINITY : small_infinity;
        act_ports = (32'(port_count) < NUM_PORTS) ? port_count : 3'(NUM_PORTS);
        c_sum = {1'b0, adv_reg} + 9'd1;
        c_new = (c_sum > {1'b0, inf}) ? inf : c_sum[7:0];
        dest_in = 32'(dest_reg) < NUM_NODES;
        didx = NW'(dest_reg);
        sidx = dcnt_reg[NW-1:0];
        pidx = pcnt_reg[PW-1:0];
        aidx = NW'(adest_reg);
        age = now_reg - last_reg[pidx];
        stat.op = op_reg;
        stat.upd_ok = {1'b0, port_reg} < act_ports;
        stat.accept = dest_in && dest_reg != self_id &&
            (!valid_reg[didx] ||
             !((hop_reg[didx] != port_reg && cost_reg[didx] <= c_new) ||
               (hop_reg[didx] == port_reg && cost_reg[didx] == c_new)));
        stat.nb_expired = seen_reg[pidx] && age > peer_timeout;
        stat.port_done = 32'(pcnt_reg) == NUM_PORTS - 1;
        stat.dest_done = 32'(dcnt_reg) == NUM_NODES - 1;
        if (op_reg == dvrt_pkg::OP_TICK) begin
            stat.dest_hit = 32'(dcnt_reg) != 32'(self_id) && valid_reg[sidx] &&
                32'(hop_reg[sidx]) == 32'(pcnt_reg);
        end else begin
            stat.dest_hit = 32'(dcnt_reg) == 32'(self_id) || valid_reg[sidx];
        end
        a_self = adest_reg == self_id;
        a_back = !a_self && hop_reg[aidx] == acnt_reg[1:0];
        a_cost = a_self ? 8'd0 : cost_reg[aidx];
        stat.adv_emit = acnt_reg < act_ports && !(split_horizon && a_back);
        stat.adv_done = acnt_reg + 3'd1 >= act_ports;
        res_kind = dvrt_pkg::KIND_ADV;
        res_port = acnt_reg[1:0];
        res_dest = adest_reg;
        res_cost = (poison_reverse && a_back) ? inf : a_cost;
        if (op_reg == dvrt_pkg::OP_LOOKUP) begin
            res_port = 2'd0;
            res_cost = 8'd0;
            res_dest = dest_reg;
            if (dest_reg == self_id) begin
                res_kind = dvrt_pkg::KIND_DELIVER;
            end else if (dest_in && valid_reg[didx] && cost_reg[didx] < inf &&
                         {1'b0, hop_reg[didx]} < act_ports) begin
                res_kind = dvrt_pkg::KIND_FORWARD;
                res_port = hop_reg[didx];
            end else begin
                res_kind = dvrt_pkg::KIND_DROP;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            seen_reg  <= '0;
        end else begin
            if (cmd.update) begin
                if (stat.accept) begin
                    valid_reg[didx] <= 1'b1;
                    hop_reg[didx]   <= port_reg;
                    cost_reg[didx]  <= c_new;
                end
                seen_reg[PW'(port_reg)] <= 1'b1;
                last_reg[PW'(port_reg)] <= now_reg;
            end
            if (cmd.poison) cost_reg[sidx] <= inf;
            if (cmd.forget) seen_reg[pidx] <= 1'b0;
        end
        if (cmd.load) begin
            op_reg   <= s_operation;
            port_reg <= s_in_port;
            dest_reg <= s_dest_id;
            adv_reg  <= s_adv_cost;
            now_reg  <= s_now;
        end
        if (cmd.scan_start) begin
            dcnt_reg <= '0;
            pcnt_reg <= '0;
        end else begin
            if (cmd.next_dest) dcnt_reg <= cmd.next_port ? '0 : dcnt_reg + 1'b1;
            if (cmd.next_port) pcnt_reg <= pcnt_reg + 1'b1;
        end
        if (cmd.adv_start) begin
            acnt_reg  <= '0;
            adest_reg <= cmd.adv_sel_scan ? 4'(dcnt_reg) : dest_reg;
        end else if (cmd.adv_step) begin
            acnt_reg <= acnt_reg + 3'd1;
        end
    end
endmodule

[hdl/dvrt_ctrl.sv]
// Sequencer for updates, neighbour scans, table adverts and lookups.
`include "distance_vector_route_table_assert.svh"
module dvrt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_last,
    output logic                 out_load,
    output dvrt_pkg::dvrt_cmd_t  cmd,
    input  dvrt_pkg::dvrt_stat_t stat
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_DECODE, ST_PSCAN, ST_DSCAN, ST_ADV, ST_LOOK, ST_FLUSH
    } state_t;

    state_t state_reg, ret_reg;
    logic [6:0] cnt_reg;
    logic       pend_reg;   // a result is held for the output stage
    logic       tick_reg;   // advert belongs to tick scan
    logic       v_reg;
    logic       last_reg;
    logic       free;
    logic       more;
    logic       push;

    assign free = !v_reg || m_ready;
    assign m_valid = v_reg;
    assign m_last = last_reg;
    assign s_ready = state_reg == ST_IDLE && free && !pend_reg;

    // true when a further result may follow the current advert slot
    always_comb begin
        more = !stat.adv_done;
        if (state_reg == ST_ADV && stat.adv_done) more = 1'b0;
    end

    always_comb begin
        cmd = '0;
        out_load = 1'b0;
        cmd.load = s_valid && s_ready;
        case (state_reg)
            ST_DECODE: begin
                cmd.scan_start = 1'b1;
                cmd.update = stat.op == dvrt_pkg::OP_UPDATE && stat.upd_ok;
                cmd.adv_start = cmd.update;
            end
            ST_PSCAN: begin
                if (!stat.nb_expired) cmd.next_port = !stat.port_done;
            end
            ST_DSCAN: begin
                cmd.poison = tick_reg && stat.dest_hit;
                cmd.adv_start = stat.dest_hit;
                cmd.adv_sel_scan = 1'b1;
                // step past the entry whether or not it is advertised
                cmd.next_dest = !stat.dest_done;
                if (stat.dest_done && tick_reg) begin
                    cmd.forget = 1'b1;
                    cmd.next_port = !stat.port_done;
                    cmd.next_dest = !stat.port_done;
                end
            end
            ST_ADV: begin
                if (free) begin
                    cmd.adv_step = 1'b1;
                    out_load = stat.adv_emit && cnt_reg < 7'(dvrt_pkg::MAX_RESULTS);
                end
            end
            ST_LOOK: out_load = free;
            default: ;
        endcase
    end

    // present a result on the output register
    always_comb begin
        case (state_reg)
            ST_ADV:   push = out_load && pend_reg;
            ST_LOOK:  push = free;
            ST_FLUSH: push = free && pend_reg;
            default:  push = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            tick_reg  <= 1'b0;
            v_reg     <= 1'b0;
            last_reg  <= 1'b0;
        end else begin
            if (push) v_reg <= 1'b1;
            else if (m_ready) v_reg <= 1'b0;
            // a held result becomes last once the transaction ends
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        state_reg <= ST_DECODE;
                        cnt_reg <= '0;
                    end
                end
                ST_DECODE: begin
                    tick_reg <= stat.op == dvrt_pkg::OP_TICK;
                    case (stat.op)
                        dvrt_pkg::OP_UPDATE: begin
                            state_reg <= (stat.upd_ok && stat.accept) ? ST_ADV : ST_FLUSH;
                            ret_reg <= ST_FLUSH;
                        end
                        dvrt_pkg::OP_TICK: state_reg <= ST_PSCAN;
                        dvrt_pkg::OP_PERIOD: state_reg <= ST_DSCAN;
                        default: state_reg <= ST_LOOK;
                    endcase
                end
                ST_PSCAN: begin
                    if (stat.nb_expired) state_reg <= ST_DSCAN;
                    else if (stat.port_done) state_reg <= ST_FLUSH;
                end
                ST_DSCAN: begin
                    if (!stat.dest_done) ret_reg <= ST_DSCAN;
                    else if (!tick_reg || stat.port_done) ret_reg <= ST_FLUSH;
                    else ret_reg <= ST_PSCAN;
                    if (stat.dest_hit) begin
                        state_reg <= ST_ADV;
                    end else if (stat.dest_done) begin
                        if (!tick_reg || stat.port_done) state_reg <= ST_FLUSH;
                        else state_reg <= ST_PSCAN;
                    end
                end
                ST_ADV: begin
                    if (free) begin
                        if (out_load) begin
                            if (pend_reg) last_reg <= 1'b0;
                            pend_reg <= 1'b1;
                            cnt_reg <= cnt_reg + 7'd1;
                        end
                        if (!more) state_reg <= ret_reg;
                    end
                end
                ST_LOOK: begin
                    if (free) begin
                        last_reg <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_FLUSH: begin
                    if (free) begin
                        if (pend_reg) begin
                            last_reg <= 1'b1;
                            pend_reg <= 1'b0;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `DVRT_ASSERT_IMPL(a_ready_idle, aclk, aresetn, s_ready, state_reg == ST_IDLE)
    `DVRT_ASSERT_IMPL(a_cap, aclk, aresetn, 1'b1, cnt_reg <= 7'(dvrt_pkg::MAX_RESULTS))
    `DVRT_ASSERT_NEXT(a_look, aclk, aresetn, state_reg == ST_LOOK && free, m_valid && m_last)
endmodule

[hdl/distance_vector_route_table.sv]
// Top level of the distance-vector route table.
// Input channel s_*: one transaction carries an operation (update, check-alive
// tick, periodic advertise, forward lookup). Result channel m_*: each result
// carries kind, port, destination and cost; m_last marks the final result of
// one input transaction. Operations that cause no result emit nothing.
// A lookup result is loaded straight into the output register. An accepted
// update walks the advert counter over each active port (at least one).
// A tick checks one neighbour a cycle and walks each timed-out neighbour over
// all destinations, one entry a cycle while no entry is advertised, and walks
// the advert counter over each active port (at least one) for each advertised
// entry; a periodic advertise walks the table the same way. One transaction is
// worked at a time; the next input is taken once the previous results have
// entered the output register.
// One result is held back in a staging register so m_last can be set on it.
// A receiver stall holds the output register and pauses the sequencer.
// Synchronous reset clears route valid bits, neighbour seen flags, the
// configuration registers to defaults and the output valid.
// Configuration: APB writes at byte address 4*index; pready always high.
`include "distance_vector_route_table_assert.svh"
module distance_vector_route_table #(
    parameter int NUM_NODES = 16,
    parameter int NUM_PORTS = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [1:0]  s_in_port,
    input  logic [3:0]  s_dest_id,
    input  logic [7:0]  s_adv_cost,
    input  logic [31:0] s_now,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [1:0]  m_out_port,
    output logic [3:0]  m_out_dest,
    output logic [7:0]  m_out_cost,
    output logic        m_last
);
    logic [3:0]  self_reg;
    logic [7:0]  inf_reg;
    logic [31:0] tmo_reg;
    logic        split_reg;
    logic        poison_reg;
    logic [2:0]  pcnt_reg;
    logic [2:0]  ridx;
    logic        out_load;
    logic [1:0]  r_kind, h_kind_reg;
    logic [1:0]  r_port, h_port_reg;
    logic [3:0]  r_dest, h_dest_reg;
    logic [7:0]  r_cost, h_cost_reg;
    logic        lookup_load;
    logic        v_q;
    dvrt_pkg::dvrt_cmd_t  cmd;
    dvrt_pkg::dvrt_stat_t stat;

    assign pready = 1'b1;
    assign ridx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            self_reg   <= '0;
            inf_reg    <= 8'd16;
            tmo_reg    <= 32'd180;
            split_reg  <= 1'b0;
            poison_reg <= 1'b0;
            pcnt_reg   <= 3'd4;
        end else if (psel && penable && pwrite) begin
            case (ridx)
                dvrt_pkg::REG_SELF_ID:  self_reg   <= pwdata[3:0];
                dvrt_pkg::REG_INFINITY: inf_reg    <= pwdata[7:0];
                dvrt_pkg::REG_TIMEOUT:  tmo_reg    <= pwdata;
                dvrt_pkg::REG_SPLIT:    split_reg  <= pwdata[0];
                dvrt_pkg::REG_POISON:   poison_reg <= pwdata[0];
                dvrt_pkg::REG_PORT_CNT: pcnt_reg   <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (ridx)
            dvrt_pkg::REG_SELF_ID:  prdata = {28'd0, self_reg};
            dvrt_pkg::REG_INFINITY: prdata = {24'd0, inf_reg};
            dvrt_pkg::REG_TIMEOUT:  prdata = tmo_reg;
            dvrt_pkg::REG_SPLIT:    prdata = {31'd0, split_reg};
            dvrt_pkg::REG_POISON:   prdata = {31'd0, poison_reg};
            dvrt_pkg::REG_PORT_CNT: prdata = {29'd0, pcnt_reg};
            default:                prdata = '0;
        endcase
    end

    dvrt_ctrl u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .m_valid(v_q), .m_ready,
        .m_last, .out_load, .cmd, .stat
    );

    dvrt_datapath #(.NUM_NODES(NUM_NODES), .NUM_PORTS(NUM_PORTS)) u_dp (
        .aclk, .aresetn, .cmd, .stat, .s_operation, .s_in_port, .s_dest_id,
        .s_adv_cost, .s_now, .self_id(self_reg), .small_infinity(inf_reg),
        .peer_timeout(tmo_reg), .split_horizon(split_reg),
        .poison_reverse(poison_reg), .port_count(pcnt_reg),
        .res_kind(r_kind), .res_port(r_port), .res_dest(r_dest), .res_cost(r_cost)
    );

    assign m_valid = v_q;
    assign lookup_load = out_load && stat.op == dvrt_pkg::OP_LOOKUP;

    // staging register feeds the output register one result behind; lookup results bypass it
    always_ff @(posedge aclk) begin
        if (out_load) begin
            h_kind_reg <= r_kind;
            h_port_reg <= r_port;
            h_dest_reg <= r_dest;
            h_cost_reg <= r_cost;
        end
        if (lookup_load) begin
            m_kind     <= r_kind;
            m_out_port <= r_port;
            m_out_dest <= r_dest;
            m_out_cost <= r_cost;
        end else if (!v_q || m_ready) begin
            m_kind     <= h_kind_reg;
            m_out_port <= h_port_reg;
            m_out_dest <= h_dest_reg;
            m_out_cost <= h_cost_reg;
        end
    end

    `DVRT_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid)
    `DVRT_ASSERT_IMPL(a_no_take, aclk, aresetn, s_ready, !m_valid || m_ready)
    `DVRT_ASSERT_NEXT(a_stable, aclk, aresetn, m_valid && !m_ready, $stable(m_kind) && $stable(m_out_port) && $stable(m_out_dest) && $stable(m_out_cost) && $stable(m_last))
endmodule
